// ===== rtl/pbrle_pkg.sv =====
// Shared types and constants for the PackBits run-length decoder.
package pbrle_pkg;

	localparam int LANES = 4;
	// Lanes used per run word: only four lane fields exist
	localparam int LANE_USED = (LANES < 1) ? 1 : ((LANES > 4) ? 4 : LANES);
	localparam logic [2:0] LANE_W = 3'(LANE_USED);

	localparam int TDATA_W = 56;
	localparam int TUSER_W = 2;

	localparam logic [7:0] LIT_LIMIT = 8'd128;
	localparam logic [15:0] TOTAL_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		M_HDR = 3'b001,
		M_LIT = 3'b010,
		M_RUN = 3'b100
	} mode_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} seq_t;

	typedef struct packed {
		logic [7:0]  left;
		logic [2:0]  cap;
		logic        add_one;
		logic [15:0] total;
	} unit_req_t;

	typedef struct packed {
		logic [2:0]  cnt;
		logic [7:0]  left;
		logic [15:0] total;
	} unit_rsp_t;

endpackage

// ===== rtl/pbrle_unit.sv =====
// Shared countdown and saturating total unit for literal and run words.
module pbrle_unit (
	input  pbrle_pkg::unit_req_t req,
	output pbrle_pkg::unit_rsp_t rsp
);
	import pbrle_pkg::*;

	logic [2:0]  cnt;
	logic [2:0]  add_n;
	logic [16:0] sum;

	always_comb begin
		// Take at most cap bytes from what is left
		if (req.left < {5'd0, req.cap}) begin
			cnt = req.left[2:0];
		end else begin
			cnt = req.cap;
		end
		add_n = req.add_one ? 3'd1 : cnt;
		sum = {1'b0, req.total} + {14'd0, add_n};
		rsp.cnt = cnt;
		rsp.left = req.left - {5'd0, cnt};
		rsp.total = sum[16] ? TOTAL_MAX : sum[15:0];
	end

endmodule

// ===== rtl/packbits_rle_decoder_top.sv =====
// PackBits run-length decoder: header sequencer, run word emitter and output register.
//
// Usage:
//   Slave channel s_*: one compressed byte per transaction in s_tdata[7:0],
//   s_tlast marks the last byte of a compressed block.
//   Master channel m_*: decoded words of up to four bytes. A header byte
//   gives no result (except a block-end marker when it closes a block), a
//   literal byte gives one single-byte word, a run value byte gives
//   ceil(n/4) words of the repeated byte with m_tuser[0] on the last one.
//   m_tlast closes the block; m_tuser[1] flags a block cut inside a header
//   or literal.
// Timing:
//   Header and literal bytes are taken whenever the output register is free; the
//   result appears in the output register the cycle after the transaction. A run value
//   byte holds s_tready low while the shared countdown unit emits one word per cycle
//   while the output register is free, ceil(n/4) words for a run of n bytes.
// Reset clears the sequencer, the decode mode, the counters and m_tvalid.
// When the receiver stalls, the output register holds its word, s_tready
// drops and the run countdown pauses until the word is taken.
module packbits_rle_decoder_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [7:0]                        s_tdata, // [7:0] in_byte
	input  logic                              s_tlast, // block_last
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// [7:0] lane0, [15:8] lane1, [23:16] lane2, [31:24] lane3,
	// [34:32] byte_count, [50:35] total_bytes, [55:51] zero
	output logic [pbrle_pkg::TDATA_W-1:0]     m_tdata,
	output logic                              m_tlast, // block_end
	output logic [pbrle_pkg::TUSER_W-1:0]     m_tuser  // [0] run_last, [1] truncated
);
	import pbrle_pkg::*;

	seq_t        st_q;
	mode_t       mode_q;
	logic [7:0]  lit_left_q;
	logic [7:0]  run_left_q;
	logic [15:0] total_q;
	logic [7:0]  val_q;
	logic        last_q;

	logic                m_tvalid_q;
	logic [TDATA_W-1:0]  m_tdata_q;
	logic                m_tlast_q;
	logic [TUSER_W-1:0]  m_tuser_q;

	logic      out_free;
	logic      in_acc;
	unit_req_t ureq;
	unit_rsp_t ursp;

	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (st_q == ST_IDLE) && out_free;
	assign in_acc = s_tvalid && s_tready;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;
	assign m_tlast = m_tlast_q;
	assign m_tuser = m_tuser_q;

	always_comb begin
		ureq.total = total_q;
		if (st_q == ST_RUN) begin
			ureq.left = run_left_q;
			ureq.cap = LANE_W;
			ureq.add_one = 1'b0;
		end else begin
			ureq.left = lit_left_q;
			ureq.cap = 3'd1;
			ureq.add_one = 1'b1;
		end
	end

	pbrle_unit u_unit (
		.req (ureq),
		.rsp (ursp)
	);

	function automatic logic [TDATA_W-1:0] pack_word(input logic [7:0] v,
			input logic [2:0] cnt, input logic [15:0] tot);
		logic [TDATA_W-1:0] w;
		w = '0;
		for (int k = 0; k < 4; k++) begin
			if (3'(k) < cnt) begin
				w[k*8 +: 8] = v;
			end
		end
		w[34:32] = cnt;
		w[50:35] = tot;
		return w;
	endfunction

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			mode_q <= M_HDR;
			lit_left_q <= '0;
			run_left_q <= '0;
			total_q <= '0;
			last_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			if (in_acc) begin
				unique case (mode_q)
					M_LIT: begin
						m_tvalid_q <= 1'b1;
						lit_left_q <= ursp.left;
						total_q <= ursp.total;
						if (ursp.left == 8'd0) begin
							mode_q <= M_HDR;
						end
						if (s_tlast) begin
							mode_q <= M_HDR;
							lit_left_q <= '0;
							total_q <= '0;
						end
					end
					M_RUN: begin
						last_q <= s_tlast;
						st_q <= ST_RUN;
					end
					default: begin
						if (s_tdata < LIT_LIMIT) begin
							lit_left_q <= s_tdata + 8'd1;
							mode_q <= M_LIT;
						end else begin
							// 257 - b, which is 2..129
							run_left_q <= 8'd1 - s_tdata;
							mode_q <= M_RUN;
						end
						if (s_tlast) begin
							m_tvalid_q <= 1'b1;
							mode_q <= M_HDR;
							lit_left_q <= '0;
							run_left_q <= '0;
							total_q <= '0;
						end
					end
				endcase
			end else if (st_q == ST_RUN && out_free) begin
				m_tvalid_q <= 1'b1;
				run_left_q <= ursp.left;
				total_q <= ursp.total;
				if (ursp.left == 8'd0) begin
					st_q <= ST_IDLE;
					mode_q <= M_HDR;
					if (last_q) begin
						total_q <= '0;
						lit_left_q <= '0;
					end
				end
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (in_acc) begin
			val_q <= s_tdata;
			unique case (mode_q)
				M_LIT: begin
					m_tdata_q <= pack_word(s_tdata, 3'd1, ursp.total);
					m_tlast_q <= s_tlast;
					m_tuser_q <= {s_tlast && (ursp.left != 8'd0), 1'b1};
				end
				M_RUN: begin
				end
				default: begin
					m_tdata_q <= pack_word(8'd0, 3'd0, total_q);
					m_tlast_q <= 1'b1;
					m_tuser_q <= 2'b11;
				end
			endcase
		end else if (st_q == ST_RUN && out_free) begin
			m_tdata_q <= pack_word(val_q, ursp.cnt, ursp.total);
			m_tlast_q <= last_q && (ursp.left == 8'd0);
			m_tuser_q <= {1'b0, ursp.left == 8'd0};
		end
	end

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RUN |-> run_left_q != 8'd0)
		else $error("run countdown active with nothing left");

	a_count_cap: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> m_tdata_q[34:32] <= LANE_W)
		else $error("word carries more bytes than lanes");

	a_marker: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tdata_q[34:32] == 3'd0 |-> m_tlast_q && m_tuser_q == 2'b11)
		else $error("empty word that is not a truncation marker");

	a_trunc_end: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q && m_tuser_q[1] |-> m_tlast_q && m_tuser_q[0])
		else $error("truncation flag without block end");

	a_run_mode: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_RUN |-> mode_q == M_RUN)
		else $error("run countdown outside run mode");

endmodule
